>>> design/ptc_pkg.sv
// Shared widths, calibration and sideband types for the pressure and temperature compensation.
package ptc_pkg;

  localparam int RawW   = 20;
  localparam int CalW   = 48;
  localparam int TempW  = 15;
  localparam int PresW  = 25;
  localparam int WordW  = 64;
  localparam int DenW   = 31;

  // Number of pipelined divider stages, one quotient bit each.
  localparam int DivStages = WordW;

  localparam logic signed [TempW-1:0] TempMin = -15'sd4000;
  localparam logic signed [TempW-1:0] TempMax = 15'sd8500;
  localparam logic [PresW-1:0]        PresMax = 25'd28160000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgTemp   = 2'd0,
    CfgPressA = 2'd1,
    CfgPressB = 2'd2,
    CfgPressC = 2'd3
  } cfg_idx_e;

  // Unpacked calibration words; signedness is applied where they are used.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // Sideband that travels alongside the divider.
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic             invalid;
    logic             qneg;
  } side_t;

  // One finished result.
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [PresW-1:0] pres;
    logic             invalid;
  } res_t;

endpackage

>>> design/ptc_front.sv
// Front pipeline: temperature, fine value and the pressure numerator and divisor.
module ptc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [ptc_pkg::RawW-1:0]         adc_p_i,
  input  logic [ptc_pkg::RawW-1:0]         adc_t_i,
  input  ptc_pkg::cal_t                    cal_i,
  output logic                             valid_o,
  output logic [ptc_pkg::WordW-1:0]        mn_o,
  output logic [ptc_pkg::DenW-1:0]         md_o,
  output ptc_pkg::side_t                   side_o
);

  localparam int NStages  = 12;
  localparam int PdLag    = 7;
  localparam int TempLag  = 6;
  localparam logic signed [20:0] TFullMin = -21'sd4000;
  localparam logic signed [20:0] TFullMax = 21'sd8500;

  logic [NStages:1] v_q;

  // Stage 1: offsets against T1 and the pressure complement.
  logic signed [17:0] a0_q, a0_d;
  logic signed [16:0] b0_q, b0_d;
  logic [20:0]        pd1_q, pd1_d;

  assign a0_d  = $signed({1'b0, adc_t_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
  assign b0_d  = $signed({1'b0, adc_t_i[19:4]}) - $signed({1'b0, cal_i.t1});
  assign pd1_d = 21'd1048576 - {1'b0, adc_p_i};

  // Stage 2: first temperature products.
  logic signed [33:0] ma_q, ma_d, mb_q, mb_d;
  assign ma_d = a0_q * $signed(cal_i.t2);
  assign mb_d = b0_q * b0_q;

  // Stage 3: scaled terms and the T3 product.
  logic signed [22:0] ta_q, ta_d;
  logic signed [37:0] mt_q, mt_d;
  assign ta_d = ma_q[33:11];
  assign mt_d = $signed(mb_q[33:12]) * $signed(cal_i.t3);

  // Stage 4: fine temperature.
  logic signed [25:0] fine_q, fine_d;
  assign fine_d = $signed({{3{ta_q[22]}}, ta_q}) + $signed({{2{mt_q[37]}}, mt_q[37:14]});

  // Stage 5: temperature in hundredths with saturation, and the pressure offset.
  logic signed [28:0] f29, tw;
  logic signed [20:0] tfull;
  logic [14:0]        t5_q, t5_d;
  logic signed [26:0] x_q, x_d;

  always_comb begin
    f29   = {{3{fine_q[25]}}, fine_q};
    tw    = (f29 <<< 2) + f29 + 29'sd128;
    tfull = tw[28:8];
    if (tfull < TFullMin) begin
      t5_d = ptc_pkg::TempMin;
    end else if (tfull > TFullMax) begin
      t5_d = ptc_pkg::TempMax;
    end else begin
      t5_d = tfull[14:0];
    end
  end
  assign x_d = $signed({fine_q[25], fine_q}) - 27'sd128000;

  // Stage 6: products of the offset.
  logic signed [53:0] xx_q, xx_d;
  logic signed [42:0] xp5_q, xp5_d, xp2_q, xp2_d;
  logic signed [42:0] xp5b_q, xp2b_q;
  assign xx_d  = x_q * x_q;
  assign xp5_d = x_q * $signed(cal_i.p5);
  assign xp2_d = x_q * $signed(cal_i.p2);

  // Stage 7: square times P6 and P3, kept modulo 2^64.
  logic signed [69:0] xxp6_w, xxp3_w;
  logic [63:0]        xxp6_q, xxp3_q;
  assign xxp6_w = xx_q * $signed(cal_i.p6);
  assign xxp3_w = xx_q * $signed(cal_i.p3);

  // Stage 8: sums for the numerator offset and the divisor term.
  logic [63:0] y_q, y_d, x2_q, x2_d;
  assign y_d  = xxp6_q + ({{21{xp5b_q[42]}}, xp5b_q} << 17)
              + ({{48{cal_i.p4[15]}}, cal_i.p4} << 35);
  assign x2_d = {{8{xxp3_q[63]}}, xxp3_q[63:8]} + ({{21{xp2b_q[42]}}, xp2b_q} << 12);

  // Stage 9: biased divisor term and raw numerator.
  logic [63:0] vv_q, vv_d, n1_q, n1_d;
  logic [20:0] pd_q [PdLag];
  assign vv_d = x2_q + 64'h0000_8000_0000_0000;
  assign n1_d = {12'b0, pd_q[PdLag-1], 31'b0} - y_q;

  // Stage 10: split products by P1 and by 3125.
  logic [47:0] vlo_w, vhi_w, vlo_q;
  logic [31:0] vhi_q;
  logic [43:0] nlo_w, nhi_w, nlo_q;
  logic [31:0] nhi_q;
  assign vlo_w = vv_q[31:0] * cal_i.p1;
  assign vhi_w = vv_q[63:32] * cal_i.p1;
  assign nlo_w = n1_q[31:0] * 12'd3125;
  assign nhi_w = n1_q[63:32] * 12'd3125;

  // Stage 11: divisor and numerator words.
  logic [63:0]        x3w, nw;
  logic signed [30:0] x3_q;
  logic [63:0]        n_q;
  assign x3w = {16'b0, vlo_q} + {vhi_q, 32'b0};
  assign nw  = {20'b0, nlo_q} + {nhi_q, 32'b0};

  // Stage 12: magnitudes and quotient sign for the divider.
  logic [63:0]    mn_q;
  logic [30:0]    md_q;
  ptc_pkg::side_t side_q;
  logic [14:0]    temp_q [TempLag];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NStages-1:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q   <= a0_d;
      b0_q   <= b0_d;
      pd1_q  <= pd1_d;
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      ta_q   <= ta_d;
      mt_q   <= mt_d;
      fine_q <= fine_d;
      t5_q   <= t5_d;
      x_q    <= x_d;
      xx_q   <= xx_d;
      xp5_q  <= xp5_d;
      xp2_q  <= xp2_d;
      xxp6_q <= xxp6_w[63:0];
      xxp3_q <= xxp3_w[63:0];
      xp5b_q <= xp5_q;
      xp2b_q <= xp2_q;
      y_q    <= y_d;
      x2_q   <= x2_d;
      vv_q   <= vv_d;
      n1_q   <= n1_d;
      vlo_q  <= vlo_w;
      vhi_q  <= vhi_w[31:0];
      nlo_q  <= nlo_w;
      nhi_q  <= nhi_w[31:0];
      x3_q   <= x3w[63:33];
      n_q    <= nw;
      mn_q   <= n_q[63] ? (64'd0 - n_q) : n_q;
      md_q   <= x3_q[30] ? (31'd0 - x3_q) : x3_q;
      side_q.temp    <= temp_q[TempLag-1];
      side_q.invalid <= (x3_q == 31'sd0);
      side_q.qneg    <= n_q[63] ^ x3_q[30];
      // Delay lines for the pressure complement and the finished temperature.
      pd_q[0]   <= pd1_q;
      temp_q[0] <= t5_q;
      for (int i = 1; i < PdLag; i++) begin
        pd_q[i] <= pd_q[i-1];
      end
      for (int i = 1; i < TempLag; i++) begin
        temp_q[i] <= temp_q[i-1];
      end
    end
  end

  assign valid_o = v_q[NStages];
  assign mn_o    = mn_q;
  assign md_o    = md_q;
  assign side_o  = side_q;

endmodule

>>> design/ptc_div.sv
// Pipelined restoring divider: one quotient bit per stage over the magnitudes.
module ptc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ptc_pkg::WordW-1:0]   mn_i,
  input  logic [ptc_pkg::DenW-1:0]    md_i,
  input  ptc_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [ptc_pkg::WordW-1:0]   q_o,
  output ptc_pkg::side_t              side_o
);

  localparam int N  = ptc_pkg::DivStages;
  localparam int WW = ptc_pkg::WordW;
  localparam int DW = ptc_pkg::DenW;

  logic [N-1:0]   v_q;
  logic [WW-1:0]  nq_q   [N];
  logic [DW-1:0]  rem_q  [N];
  logic [DW-1:0]  md_q   [N];
  ptc_pkg::side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           pv;
    logic [WW-1:0]  pnq;
    logic [DW-1:0]  prem, pmd;
    ptc_pkg::side_t pside;
    logic [DW:0]    trial, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign pnq   = mn_i;
      assign prem  = '0;
      assign pmd   = md_i;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign pnq   = nq_q[k-1];
      assign prem  = rem_q[k-1];
      assign pmd   = md_q[k-1];
      assign pside = side_q[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign trial = {prem, pnq[WW-1]};
    assign diff  = trial - {1'b0, pmd};
    assign ge    = (trial >= {1'b0, pmd});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]   <= {pnq[WW-2:0], ge};
        rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        md_q[k]   <= pmd;
        side_q[k] <= pside;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign q_o     = nq_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

>>> design/ptc_back.sv
// Back pipeline: signed quotient, P7 to P9 correction terms and pressure saturation.
module ptc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ptc_pkg::WordW-1:0]   q_i,
  input  ptc_pkg::side_t              side_i,
  input  ptc_pkg::cal_t               cal_i,
  output logic                        valid_o,
  output ptc_pkg::res_t               res_o
);

  localparam int NStages = 7;

  logic [NStages:1] v_q;
  ptc_pkg::side_t   side_q [NStages-1];

  // Stage 1: apply the quotient sign.
  logic [63:0] p1_q;

  // Stage 2: split products P9 times a and P8 times p.
  logic [63:0]        a64;
  logic signed [48:0] m9lo_w, m8lo_w;
  logic signed [47:0] m9hi_w, m8hi_w;
  logic signed [48:0] m9lo_q, m8lo_q;
  logic [31:0]        m9hi_q, m8hi_q;
  logic [63:0]        p2_q, a2_q;
  assign a64    = {{13{p1_q[63]}}, p1_q[63:13]};
  assign m9lo_w = $signed({1'b0, a64[31:0]}) * $signed(cal_i.p9);
  assign m9hi_w = $signed(a64[63:32]) * $signed(cal_i.p9);
  assign m8lo_w = $signed({1'b0, p1_q[31:0]}) * $signed(cal_i.p8);
  assign m8hi_w = $signed(p1_q[63:32]) * $signed(cal_i.p8);

  // Stage 3: join the halves.
  logic [63:0] m9w, y8w;
  logic [63:0] m9_q, y3_q, p3_q, a3_q;
  assign m9w = {{15{m9lo_q[48]}}, m9lo_q} + {m9hi_q, 32'b0};
  assign y8w = {{15{m8lo_q[48]}}, m8lo_q} + {m8hi_q, 32'b0};

  // Stage 4: partial products of the second factor a, modulo 2^64.
  logic [63:0] ll_w, c1_w, c2_w;
  logic [63:0] ll_q, p4_q, y4_q;
  logic [31:0] c1_q, c2_q;
  assign ll_w = m9_q[31:0] * a3_q[31:0];
  assign c1_w = m9_q[31:0] * a3_q[63:32];
  assign c2_w = m9_q[63:32] * a3_q[31:0];

  // Stage 5: assemble the square term and scale it.
  logic [31:0] csum;
  logic [63:0] xx9w;
  logic [63:0] x9_q, p5_q, y5_q;
  assign csum = c1_q + c2_q;
  assign xx9w = ll_q + {csum, 32'b0};

  // Stage 6: sum of the corrections.
  logic [63:0] s_q;

  // Stage 7: offset by P7 and saturate.
  logic [63:0]       rw;
  logic [ptc_pkg::PresW-1:0] pres_d;
  ptc_pkg::res_t     res_q;
  assign rw = {{8{s_q[63]}}, s_q[63:8]} + ({{48{cal_i.p7[15]}}, cal_i.p7} << 4);

  always_comb begin
    if (side_q[NStages-2].invalid || rw[63]) begin
      pres_d = '0;
    end else if (rw > {39'b0, ptc_pkg::PresMax}) begin
      pres_d = ptc_pkg::PresMax;
    end else begin
      pres_d = rw[ptc_pkg::PresW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NStages-1:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= side_i.qneg ? (64'd0 - q_i) : q_i;
      m9lo_q <= m9lo_w;
      m9hi_q <= m9hi_w[31:0];
      m8lo_q <= m8lo_w;
      m8hi_q <= m8hi_w[31:0];
      p2_q   <= p1_q;
      a2_q   <= a64;
      m9_q   <= m9w;
      y3_q   <= {{19{y8w[63]}}, y8w[63:19]};
      p3_q   <= p2_q;
      a3_q   <= a2_q;
      ll_q   <= ll_w;
      c1_q   <= c1_w[31:0];
      c2_q   <= c2_w[31:0];
      p4_q   <= p3_q;
      y4_q   <= y3_q;
      x9_q   <= {{25{xx9w[63]}}, xx9w[63:25]};
      p5_q   <= p4_q;
      y5_q   <= y4_q;
      s_q    <= p5_q + x9_q + y5_q;
      res_q.temp    <= side_q[NStages-2].temp;
      res_q.pres    <= pres_d;
      res_q.invalid <= side_q[NStages-2].invalid;
      side_q[0] <= side_i;
      for (int i = 1; i < NStages-1; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = v_q[NStages];
  assign res_o   = res_q;

endmodule

>>> design/ptc_obuf.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
module ptc_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptc_pkg::res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output ptc_pkg::res_t data_o
);

  ptc_pkg::res_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rp_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

>>> design/pressure_temperature_compensation.sv
// Top level of the pipelined pressure and temperature compensation block.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: raw_pressure, raw_temperature
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: temperature_centi, pressure_q17_8;
//                                               tuser: pressure_invalid
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// One beat enters per cycle while the pipeline advances; a result passes through
// 12 front stages, 64 divider stages (one quotient bit each), 7 back stages
// and the output buffer entry.
// The whole pipeline advances unless its last stage holds a result and the
// two-entry output buffer is full; s_axis_tready follows the same advance signal.
// Reset clears the valid bits, the buffer pointers and the calibration registers.
module pressure_temperature_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [19:0] raw_pressure, [39:20] raw_temperature
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [14:0] temperature_centi, [39:15] pressure_q17_8
  output logic [0:0]  m_axis_tuser,   // [0] pressure_invalid
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [ptc_pkg::CalW-1:0] cfg_wdata_i
);

  logic [ptc_pkg::CalW-1:0] cal_temp_q, cal_pa_q, cal_pb_q, cal_pc_q;
  ptc_pkg::cal_t            cal;

  // Calibration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q <= '0;
      cal_pa_q   <= '0;
      cal_pb_q   <= '0;
      cal_pc_q   <= '0;
    end else if (cfg_we_i) begin
      case (ptc_pkg::cfg_idx_e'(cfg_idx_i))
        ptc_pkg::CfgTemp:   cal_temp_q <= cfg_wdata_i;
        ptc_pkg::CfgPressA: cal_pa_q   <= cfg_wdata_i;
        ptc_pkg::CfgPressB: cal_pb_q   <= cfg_wdata_i;
        ptc_pkg::CfgPressC: cal_pc_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Calibration word unpacking.
  always_comb begin
    cal.t1 = cal_temp_q[15:0];
    cal.t2 = cal_temp_q[31:16];
    cal.t3 = cal_temp_q[47:32];
    cal.p1 = cal_pa_q[15:0];
    cal.p2 = cal_pa_q[31:16];
    cal.p3 = cal_pa_q[47:32];
    cal.p4 = cal_pb_q[15:0];
    cal.p5 = cal_pb_q[31:16];
    cal.p6 = cal_pb_q[47:32];
    cal.p7 = cal_pc_q[15:0];
    cal.p8 = cal_pc_q[31:16];
    cal.p9 = cal_pc_q[47:32];
  end

  logic                       adv, buf_full;
  logic                       f_valid, d_valid, b_valid;
  logic [ptc_pkg::WordW-1:0]  mn, q;
  logic [ptc_pkg::DenW-1:0]   md;
  ptc_pkg::side_t             f_side, d_side;
  ptc_pkg::res_t              b_res, o_res;

  // Pipeline advance from registered state only.
  assign adv           = !b_valid || !buf_full;
  assign s_axis_tready = adv;

  ptc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .adc_p_i (s_axis_tdata[19:0]),
    .adc_t_i (s_axis_tdata[39:20]),
    .cal_i   (cal),
    .valid_o (f_valid),
    .mn_o    (mn),
    .md_o    (md),
    .side_o  (f_side)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .mn_i    (mn),
    .md_i    (md),
    .side_i  (f_side),
    .valid_o (d_valid),
    .q_o     (q),
    .side_o  (d_side)
  );

  ptc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_valid),
    .q_i     (q),
    .side_i  (d_side),
    .cal_i   (cal),
    .valid_o (b_valid),
    .res_o   (b_res)
  );

  ptc_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv && b_valid),
    .data_i  (b_res),
    .full_o  (buf_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (o_res)
  );

  assign m_axis_tdata = {o_res.pres, o_res.temp};
  assign m_axis_tuser = o_res.invalid;

endmodule

>>> test/pressure_temperature_compensation_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pressure and temperature compensation stream block.
module pressure_temperature_compensation_tb;

  // Holds the calibration copy, computes compensated results and checks output beats.
  class comp_scoreboard;
    logic [ptc_pkg::CalW-1:0] cal[4];
    ptc_pkg::res_t            pending[$];
    int                       errors;

    function new();
      foreach (cal[i]) cal[i] = '0;
      errors = 0;
    endfunction

    static function logic signed [63:0] sx(logic [15:0] w);
      return {{48{w[15]}}, w};
    endfunction

    static function logic signed [63:0] sdiv(logic signed [63:0] n, logic signed [63:0] d);
      logic [63:0] mn;
      logic [63:0] md;
      logic [63:0] q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q  = mn / md;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    // Integer compensation with 64-bit wrapping products and sums.
    function ptc_pkg::res_t compensate(logic [ptc_pkg::RawW-1:0] adc_p,
                                       logic [ptc_pkg::RawW-1:0] adc_t);
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] a, b, fine, x, y, p, tc;
      ptc_pkg::res_t r;
      t1 = {48'd0, cal[ptc_pkg::CfgTemp][15:0]};
      t2 = sx(cal[ptc_pkg::CfgTemp][31:16]);
      t3 = sx(cal[ptc_pkg::CfgTemp][47:32]);
      p1 = {48'd0, cal[ptc_pkg::CfgPressA][15:0]};
      p2 = sx(cal[ptc_pkg::CfgPressA][31:16]);
      p3 = sx(cal[ptc_pkg::CfgPressA][47:32]);
      p4 = sx(cal[ptc_pkg::CfgPressB][15:0]);
      p5 = sx(cal[ptc_pkg::CfgPressB][31:16]);
      p6 = sx(cal[ptc_pkg::CfgPressB][47:32]);
      p7 = sx(cal[ptc_pkg::CfgPressC][15:0]);
      p8 = sx(cal[ptc_pkg::CfgPressC][31:16]);
      p9 = sx(cal[ptc_pkg::CfgPressC][47:32]);

      // Fine temperature and its saturated value in hundredths of a degree.
      a    = ({44'd0, adc_t} >> 3) - (t1 << 1);
      a    = (a * t2) >>> 11;
      b    = ({44'd0, adc_t} >> 4) - t1;
      b    = (((b * b) >>> 12) * t3) >>> 14;
      fine = a + b;
      tc   = (fine * 5 + 128) >>> 8;
      if (tc < -4000) tc = -4000;
      if (tc > 8500) tc = 8500;
      r.temp = tc[ptc_pkg::TempW-1:0];

      // Pressure, driven by the fine temperature.
      x = fine - 128000;
      y = x * x * p6;
      y = y + x * p5 * (64'sd1 <<< 17);
      y = y + p4 * (64'sd1 <<< 35);
      x = ((x * x * p3) >>> 8) + x * p2 * 4096;
      x = (((64'sd1 <<< 47) + x) * p1) >>> 33;
      if (x == 0) begin
        r.pres    = '0;
        r.invalid = 1'b1;
      end else begin
        p = 1048576 - {44'd0, adc_p};
        p = sdiv(((p << 31) - y) * 3125, x);
        a = p >>> 13;
        x = (p9 * a * a) >>> 25;
        y = (p8 * p) >>> 19;
        p = ((p + x + y) >>> 8) + p7 * 16;
        if (p < 0) p = 0;
        if (p > 28160000) p = 28160000;
        r.pres    = p[ptc_pkg::PresW-1:0];
        r.invalid = 1'b0;
      end
      return r;
    endfunction

    function void note_input(logic [ptc_pkg::RawW-1:0] adc_p,
                             logic [ptc_pkg::RawW-1:0] adc_t);
      pending.push_back(compensate(adc_p, adc_t));
    endfunction

    function void check_result(logic [39:0] data, logic inv);
      ptc_pkg::res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat data=%h user=%b", $realtime, data, inv);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[14:0] !== e.temp) begin
        $display("%0t: temperature expected %0d actual %0d", $realtime,
                 $signed(e.temp), $signed(data[14:0]));
        errors++;
      end
      if (data[39:15] !== e.pres) begin
        $display("%0t: pressure expected %0d actual %0d", $realtime, e.pres, data[39:15]);
        errors++;
      end
      if (inv !== e.invalid) begin
        $display("%0t: invalid flag expected %b actual %b", $realtime, e.invalid, inv);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [39:0]              s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [39:0]              m_axis_tdata;
  logic [0:0]               m_axis_tuser;
  logic                     cfg_we_i;
  logic [1:0]               cfg_idx_i;
  logic [ptc_pkg::CalW-1:0] cfg_wdata_i;

  comp_scoreboard sb;
  int             cycles;
  bit             calm;       // when set, neither side idles
  int             sink_stall;

  localparam int CycleLimit = 600000;

  pressure_temperature_compensation u_top (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Result side: check each beat and randomize backpressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (sink_stall > 0) begin
        sink_stall    <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        sink_stall    <= pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_cal(ptc_pkg::cfg_idx_e idx, logic [ptc_pkg::CalW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.cal[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [ptc_pkg::CalW-1:0] c0, c1, c2, c3);
    write_cal(ptc_pkg::CfgTemp, c0);
    write_cal(ptc_pkg::CfgPressA, c1);
    write_cal(ptc_pkg::CfgPressB, c2);
    write_cal(ptc_pkg::CfgPressC, c3);
  endtask

  // Present one input beat and hold it until accepted.
  task automatic send_raw(logic [ptc_pkg::RawW-1:0] adc_p, logic [ptc_pkg::RawW-1:0] adc_t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {adc_t, adc_p};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(adc_p, adc_t);
  endtask

  // Close a phase: drop valid, drain all results, let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Random raw pair, near typical sensor readings when realistic is set.
  task automatic send_random(bit realistic);
    if (realistic)
      send_raw(20'($urandom_range(600000, 250000)), 20'($urandom_range(650000, 400000)));
    else
      send_raw(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
  endtask

  // Typical calibration, with small random perturbations when jitter is set.
  task automatic write_typical(bit jitter);
    logic [15:0] w[12];
    w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
          16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
    if (jitter) foreach (w[i]) w[i] = w[i] + 16'($urandom_range(64)) - 16'd32;
    write_all({w[2], w[1], w[0]}, {w[5], w[4], w[3]},
              {w[8], w[7], w[6]}, {w[11], w[10], w[9]});
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    calm          = 1'b0;
    sink_stall    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ptc_pkg::CfgTemp;
    cfg_wdata_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset calibration: the divisor is zero, so pressure is flagged invalid.
    send_raw('0, '0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    send_raw(20'hAAAAA, 20'h55555);
    drain();

    // Typical calibration: field extremes and ordinary readings.
    write_typical(1'b0);
    send_raw('0, '0);
    send_raw(20'hFFFFF, '0);
    send_raw('0, 20'hFFFFF);
    send_raw(20'hFFFFF, 20'hFFFFF);
    send_raw(20'h55555, 20'hAAAAA);
    send_raw(20'd415148, 20'd519888);
    send_raw(20'd415148, 20'd900000);
    send_raw(20'd415148, 20'd100000);
    drain();

    // Extreme calibration words, where intermediates wrap.
    write_all({ptc_pkg::CalW{1'b1}}, {ptc_pkg::CalW{1'b1}},
              {ptc_pkg::CalW{1'b1}}, {ptc_pkg::CalW{1'b1}});
    send_raw('0, '0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    send_raw(20'h12345, 20'hFEDCB);
    drain();
    write_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_raw('0, 20'hFFFFF);
    send_raw(20'hFFFFF, '0);
    send_raw(20'h80000, 20'h80000);
    drain();
    write_all({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_raw('0, '0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    drain();

    // Random phases: mostly plausible calibration, some arbitrary words.
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph % 4 == 3);
      case (ph % 3)
        0: write_typical(1'b1);
        1: write_typical(1'b0);
        default: write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                           48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      endcase
      for (int n = 0; n < 95; n++) send_random($urandom_range(99) < 75);
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ptc_pkg.sv
design/ptc_front.sv
design/ptc_div.sv
design/ptc_back.sv
design/ptc_obuf.sv
design/pressure_temperature_compensation.sv
test/pressure_temperature_compensation_tb.sv
